### sv/tcw_pkg.sv
package tcw_pkg;

    localparam int KIND_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int CELL_W    = COLOR_W + CHAR_W;
    localparam int ROW_IN_W  = 5;
    localparam int COL_IN_W  = 7;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE     = 8'h20;
    localparam logic [COLOR_W-1:0] ATTR_DEFAULT   = 8'd7;

    // sweep modes of the screen store
    localparam logic SWEEP_FILL   = 1'b0;
    localparam logic SWEEP_SCROLL = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_sweep_ctl;

endpackage

### sv/tcw_if.sv
interface tcw_cmd_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   char_code;
    logic [ROW_IN_W-1:0] read_row;
    logic [COL_IN_W-1:0] read_column;

    modport source (output valid, kind, char_code, read_row, read_column, input ready);
    modport sink   (input valid, kind, char_code, read_row, read_column, output ready);
endinterface

interface tcw_res_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ROW_OUT_W-1:0] cursor_row_out;
    logic [COL_OUT_W-1:0] cursor_column_out;
    logic                 scrolled;
    logic [CELL_W-1:0]    cell_entry;

    modport source (output valid, cursor_row_out, cursor_column_out, scrolled, cell_entry,
                    input ready);
    modport sink   (input valid, cursor_row_out, cursor_column_out, scrolled, cell_entry,
                    output ready);
endinterface

### sv/tcw_screen.sv
module tcw_screen #(
    parameter  int COLUMNS = 80,
    parameter  int ROWS    = 25,
    localparam int CELLS   = ROWS * COLUMNS,
    localparam int ADDR_W  = $clog2(CELLS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tcw_pkg::t_sweep_ctl       i_ctl,
    input  logic [tcw_pkg::CELL_W-1:0] i_blank,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] o_rd_data,
    output logic                      o_busy
);
    import tcw_pkg::*;

    localparam int CNT_W = $clog2(CELLS + 1);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;
    logic [CELL_W-1:0] r_blank;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_mode;

    logic [CNT_W:0]    w_src;
    logic              w_src_ok;
    logic [CNT_W-1:0]  w_dst;
    logic              w_dst_copy;
    logic              w_we;
    logic              w_re;
    logic [ADDR_W-1:0] w_wa;
    logic [ADDR_W-1:0] w_ra;
    logic [CELL_W-1:0] w_wd;

    // sweep step r_cnt reads the cell one row below r_cnt (scroll mode only) and writes cell r_cnt-1
    always_comb begin
        w_src      = {1'b0, r_cnt} + (CNT_W + 1)'(COLUMNS);
        w_src_ok   = w_src < (CNT_W + 1)'(CELLS);
        w_dst      = r_cnt - 1'b1;
        w_dst_copy = (r_mode == SWEEP_SCROLL) && (w_dst < CNT_W'(CELLS - COLUMNS));
        if (r_busy) begin
            w_we = (r_cnt != '0);
            w_wa = w_dst[ADDR_W-1:0];
            w_wd = w_dst_copy ? r_rd_data : r_blank;
            w_re = (r_mode == SWEEP_SCROLL) && w_src_ok;
            w_ra = w_src[ADDR_W-1:0];
        end else begin
            w_we = i_wr_en;
            w_wa = i_wr_addr;
            w_wd = i_wr_data;
            w_re = i_rd_en;
            w_ra = i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_mode  <= SWEEP_FILL;
            r_cnt   <= '0;
            r_blank <= {ATTR_DEFAULT, CHAR_SPACE};
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(CELLS)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (i_ctl.start) begin
            r_busy  <= 1'b1;
            r_mode  <= i_ctl.mode;
            r_cnt   <= '0;
            r_blank <= i_blank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

### sv/text_console_writer.sv
// Text console writer: a ROWS x COLUMNS screen of 16-bit cells (color high byte, character low
// byte) held in one single-port-write, single-port-read synchronous memory, plus a cursor.
// After reset the block runs a clearing pass that fills the screen with grey blanks; no command
// is accepted during it, while color writes on i_cfg_we are taken. A printed character, newline,
// backspace or unused kind passes from acceptance through S_DONE to the output register; a read
// in range also passes S_READ, for the registered memory read. A clear, or any character that
// moves the cursor past the last row, sweeps the whole screen one cell per cycle through the
// memory port. One command is in work at a time; the next is accepted while the previous
// result waits in the output register.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0] i_cfg_wdata,
    tcw_cmd_if.sink                     i_cmd,
    tcw_res_if.source                   o_res
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]           r_state;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic [COLOR_W-1:0]   r_color;
    logic                 r_scrolled;
    logic [CELL_W-1:0]    r_cell;
    logic                 r_out_valid;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [COL_OUT_W-1:0] r_out_col;
    logic                 r_out_scrolled;
    logic [CELL_W-1:0]    r_out_cell;

    logic [ROW_W-1:0]     n_row;
    logic [COL_W-1:0]     n_col;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_is_nl;
    logic                 w_is_bs;
    logic [COL_W:0]       w_col_inc;
    logic                 w_wrap;
    logic                 w_last_row;
    logic [COL_W-1:0]     w_col_dec;
    logic [COL_W-1:0]     w_wcol;
    logic [ADDR_W-1:0]    w_wr_addr;
    logic [CELL_W-1:0]    w_wr_data;
    logic                 w_wr_en;
    logic                 w_rd_ok;
    logic                 w_rd_en;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic                 w_advance;
    logic                 w_scroll;
    t_sweep_ctl           w_ctl;
    logic [CELL_W-1:0]    w_rd_data;
    logic                 w_busy;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;

    always_comb begin
        w_is_nl    = (i_cmd.char_code == CHAR_NEWLINE);
        w_is_bs    = (i_cmd.char_code == CHAR_BACKSPACE);
        w_col_inc  = {1'b0, r_col} + 1'b1;
        w_wrap     = w_col_inc >= (COL_W + 1)'(COLUMNS);
        w_last_row = (r_row == ROW_W'(ROWS - 1));
        w_col_dec  = (r_col != '0) ? r_col - 1'b1 : '0;
        w_wcol     = w_is_bs ? w_col_dec : r_col;
        w_wr_addr  = ADDR_W'(r_row * COLUMNS) + ADDR_W'(w_wcol);
        w_wr_data  = {r_color, w_is_bs ? CHAR_SPACE : i_cmd.char_code};
        w_wr_en    = w_accept && (i_cmd.kind == KIND_PUT) && !w_is_nl;

        w_rd_ok    = (32'(i_cmd.read_row) < ROWS) && (32'(i_cmd.read_column) < COLUMNS);
        w_rd_addr  = ADDR_W'(32'(i_cmd.read_row) * COLUMNS + 32'(i_cmd.read_column));
        w_rd_en    = w_accept && (i_cmd.kind == KIND_READ) && w_rd_ok;

        w_advance  = (i_cmd.kind == KIND_PUT) && (w_is_nl || (!w_is_bs && w_wrap));
        w_scroll   = w_advance && w_last_row;

        w_ctl.start = w_accept && ((i_cmd.kind == KIND_CLEAR) || w_scroll);
        w_ctl.mode  = (i_cmd.kind == KIND_CLEAR) ? SWEEP_FILL : SWEEP_SCROLL;
    end

    // cursor after the step; the bottom row holds when the screen scrolls
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_accept) begin
            case (i_cmd.kind)
                KIND_PUT: begin
                    if (w_is_bs) begin
                        n_col = w_col_dec;
                    end else if (w_is_nl || w_wrap) begin
                        n_col = '0;
                    end else begin
                        n_col = w_col_inc[COL_W-1:0];
                    end
                    if (w_advance && !w_last_row) begin
                        n_row = r_row + 1'b1;
                    end
                end
                KIND_CLEAR: begin
                    n_row = '0;
                    n_col = '0;
                end
                default: begin
                end
            endcase
        end
    end

    tcw_screen #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_screen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_blank   ({r_color, CHAR_SPACE}),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_busy    (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= ATTR_DEFAULT;
        end else if (i_cfg_we) begin
            r_color <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            case (r_state)
                S_INIT: begin
                    if (!w_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_cmd.kind)
                            KIND_PUT:   r_state <= w_scroll ? S_SWEEP : S_DONE;
                            KIND_CLEAR: r_state <= S_SWEEP;
                            KIND_READ:  r_state <= w_rd_ok ? S_READ : S_DONE;
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_SWEEP: begin
                    if (!w_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // pending result of the command in work
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_scrolled <= w_scroll;
            r_cell     <= '0;
        end else if (r_state == S_READ) begin
            r_cell <= w_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_row      <= ROW_OUT_W'(r_row);
            r_out_col      <= COL_OUT_W'(r_col);
            r_out_scrolled <= r_scrolled;
            r_out_cell     <= r_cell;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.cursor_row_out    = r_out_row;
    assign o_res.cursor_column_out = r_out_col;
    assign o_res.scrolled          = r_out_scrolled;
    assign o_res.cell_entry        = r_out_cell;

endmodule
